### rtl/lptsc_pkg.sv
// Package for the length-prefixed to start-code unit converter.
// Holds payload structs, phase and command codes, and shared constants.
// No dependencies.
package lptsc_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] LEN_BYTES_RESET = 3'd4;
   localparam logic [2:0] LEN_BYTES_MIN   = 3'd1;
   localparam logic [2:0] LEN_BYTES_MAX   = 3'd4;

   localparam logic [5:0] TYPE_VPS = 6'd32;
   localparam logic [5:0] TYPE_SPS = 6'd33;
   localparam logic [5:0] TYPE_PPS = 6'd34;

   localparam logic [7:0] START_CODE_ZERO = 8'h00;
   localparam logic [7:0] START_CODE_LAST = 8'h01;

   localparam logic [2:0] BEAT_FIRST   = 3'd0;
   localparam logic [2:0] BEAT_SC_LAST = 3'd3;
   localparam logic [2:0] BEAT_BYTE    = 3'd4;

   localparam logic [0:0] CSR_LEN_FIELD_BYTES = 1'b0;

   typedef enum logic [1:0] {
      PH_LEN,
      PH_FIRST,
      PH_COPY,
      PH_DROP
   } lptsc_phase_type;

   typedef enum logic [1:0] {
      CMD_SC_ONLY,
      CMD_SC_BYTE,
      CMD_BYTE
   } lptsc_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_sample;
      logic [1:0] frame_tag;
   } lptsc_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       unit_end;
      logic       truncated;
      logic [1:0] out_tag;
      logic       step_last;
   } lptsc_rsp_type;

   typedef struct packed {
      lptsc_kind_type kind;
      logic [7:0]     data;
      logic           unit_end;
      logic           truncated;
      logic [1:0]     tag;
   } lptsc_cmd_type;

endpackage

### rtl/lptsc_front.sv
// Front end: parses length prefixes and unit types, tracks remaining bytes.
// Pushes one output command per byte that produces results. Uses lptsc_pkg.
module lptsc_front
   import lptsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [2:0]    len_bytes,
   input  logic          accept,
   input  lptsc_req_type req,
   output logic          push,
   output lptsc_cmd_type cmd
);

   lptsc_phase_type phase_ff, phase_in;
   logic [1:0]      pc_ff, pc_in;
   logic [31:0]     rem_ff, rem_in;
   logic [2:0]      nbytes;
   logic [31:0]     rem_shift;
   logic [31:0]     rem_dec;
   logic            dec_zero;
   logic [5:0]      unit_type;
   logic            is_param;

   always_comb begin
      nbytes = len_bytes;
      if (len_bytes < LEN_BYTES_MIN) nbytes = LEN_BYTES_MIN;
      if (len_bytes > LEN_BYTES_MAX) nbytes = LEN_BYTES_MAX;

      rem_shift = {rem_ff[23:0], req.data_byte};
      rem_dec   = rem_ff - 32'd1;
      dec_zero  = (rem_dec == 32'd0);
      unit_type = req.data_byte[6:1];
      is_param  = (unit_type == TYPE_VPS) || (unit_type == TYPE_SPS) ||
                  (unit_type == TYPE_PPS);

      phase_in = phase_ff;
      pc_in    = pc_ff;
      rem_in   = rem_ff;
      push     = 1'b0;
      cmd.kind      = CMD_BYTE;
      cmd.data      = req.data_byte;
      cmd.unit_end  = dec_zero | req.end_of_sample;
      cmd.truncated = req.end_of_sample & ~dec_zero;
      cmd.tag       = req.frame_tag;

      case (phase_ff)
         PH_LEN: begin
            rem_in = rem_shift;
            if (({1'b0, pc_ff} + 3'd1) >= nbytes) begin
               pc_in = 2'd0;
               if (rem_shift == 32'd0) begin
                  push          = 1'b1;
                  cmd.kind      = CMD_SC_ONLY;
                  cmd.unit_end  = 1'b1;
                  cmd.truncated = 1'b0;
               end else begin
                  phase_in = PH_FIRST;
               end
            end else begin
               pc_in = pc_ff + 2'd1;
            end
         end
         PH_FIRST: begin
            rem_in = rem_dec;
            if (is_param) begin
               phase_in = dec_zero ? PH_LEN : PH_DROP;
            end else begin
               push     = 1'b1;
               cmd.kind = CMD_SC_BYTE;
               phase_in = dec_zero ? PH_LEN : PH_COPY;
            end
         end
         PH_COPY: begin
            rem_in = rem_dec;
            push   = 1'b1;
            if (dec_zero) phase_in = PH_LEN;
         end
         PH_DROP: begin
            rem_in = rem_dec;
            if (dec_zero) phase_in = PH_LEN;
         end
         default: begin
            phase_in = PH_LEN;
         end
      endcase

      if (req.end_of_sample) begin
         phase_in = PH_LEN;
         pc_in    = 2'd0;
         rem_in   = 32'd0;
      end

      push = push & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         pc_ff    <= 2'd0;
         rem_ff   <= 32'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pc_ff    <= pc_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

### rtl/lptsc_queue.sv
// Two-entry command queue between the front and back ends.
// Uses lptsc_pkg for the command struct and depth.
module lptsc_queue
   import lptsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  lptsc_cmd_type push_cmd,
   input  logic          pop,
   output lptsc_cmd_type head,
   output logic          empty,
   output logic          full
);

   lptsc_cmd_type entry_ff [QUEUE_DEPTH];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   always_comb begin
      empty     = (count_ff == 2'd0);
      full      = (count_ff == 2'(QUEUE_DEPTH));
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

### rtl/lptsc_back.sv
// Back end: expands each queued command into output transfers,
// four start-code bytes and/or one payload byte. Uses lptsc_pkg.
module lptsc_back
   import lptsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lptsc_cmd_type head,
   input  logic          empty,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output lptsc_rsp_type rsp_payload
);

   lptsc_cmd_type cur_ff;
   logic          cur_valid_ff, cur_valid_in;
   logic [2:0]    beat_ff, beat_in;
   logic          fire;
   logic          last_beat;
   logic          advance;

   always_comb begin
      rsp_valid = cur_valid_ff;
      fire      = cur_valid_ff & ~rsp_stall;
      last_beat = (beat_ff == BEAT_BYTE) ||
                  ((cur_ff.kind == CMD_SC_ONLY) && (beat_ff == BEAT_SC_LAST));
      advance   = ~cur_valid_ff | (fire & last_beat);
      pop       = advance & ~empty;

      cur_valid_in = cur_valid_ff;
      beat_in      = beat_ff;
      if (advance) begin
         cur_valid_in = ~empty;
         beat_in      = (head.kind == CMD_BYTE) ? BEAT_BYTE : BEAT_FIRST;
      end else if (fire) begin
         beat_in = beat_ff + 3'd1;
      end

      rsp_payload.out_tag = cur_ff.tag;
      case (beat_ff)
         BEAT_SC_LAST: begin
            rsp_payload.out_byte  = START_CODE_LAST;
            rsp_payload.unit_end  = (cur_ff.kind == CMD_SC_ONLY);
            rsp_payload.truncated = 1'b0;
            rsp_payload.step_last = (cur_ff.kind == CMD_SC_ONLY);
         end
         BEAT_BYTE: begin
            rsp_payload.out_byte  = cur_ff.data;
            rsp_payload.unit_end  = cur_ff.unit_end;
            rsp_payload.truncated = cur_ff.truncated;
            rsp_payload.step_last = 1'b1;
         end
         default: begin
            rsp_payload.out_byte  = START_CODE_ZERO;
            rsp_payload.unit_end  = 1'b0;
            rsp_payload.truncated = 1'b0;
            rsp_payload.step_last = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         beat_ff      <= BEAT_FIRST;
      end else begin
         cur_valid_ff <= cur_valid_in;
         beat_ff      <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head;
   end

endmodule

### rtl/length_prefixed_to_start_code_nal_top.sv
// Converts length-prefixed video units to start-code-prefixed units, one input
// byte per transfer. Takes one byte per cycle while each byte yields at most one
// output transfer and rsp_stall is low; the back end emits one transfer per
// unstalled cycle, so a byte opening a unit yields five transfers (start code
// plus byte) and a zero-length prefix four. A two-entry command queue separates
// the parser from the output stage; req_stall is raised only while it is full.
// Parameter-set units (types 32, 33, 34) are dropped. Uses lptsc_pkg.
module length_prefixed_to_start_code_nal_top
   import lptsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  lptsc_req_type req_payload,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output lptsc_rsp_type rsp_payload,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [1:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   logic [2:0]    len_bytes_ff, len_bytes_in;
   logic          csr_write;
   logic          accept;
   logic          push;
   lptsc_cmd_type push_cmd;
   logic          pop;
   lptsc_cmd_type head;
   logic          empty;
   logic          full;

   always_comb begin
      pready       = 1'b1;
      csr_write    = psel & penable & pwrite & pready &
                     (paddr[1:1] == CSR_LEN_FIELD_BYTES);
      len_bytes_in = csr_write ? pwdata[2:0] : len_bytes_ff;
      prdata       = {29'd0, len_bytes_ff};
      req_stall    = full;
      accept       = req_valid & ~full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_bytes_ff <= LEN_BYTES_RESET;
      end else begin
         len_bytes_ff <= len_bytes_in;
      end
   end

   lptsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .len_bytes (len_bytes_ff),
      .accept    (accept),
      .req       (req_payload),
      .push      (push),
      .cmd       (push_cmd)
   );

   lptsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   lptsc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### bench/length_prefixed_to_start_code_nal_top_tb.sv
// Testbench for length_prefixed_to_start_code_nal_top: drives length-prefixed units,
// predicts the start-code output stream and checks every result transfer field by field.
// Depends on lptsc_pkg and the top-level RTL only.
module length_prefixed_to_start_code_nal_top_tb;
   import lptsc_pkg::*;

   localparam logic [1:0] LEN_BYTES_ADDR = 2'(CSR_LEN_FIELD_BYTES * 4);
   localparam int SETTLE_CYCLES = 12;
   localparam int IDLE_LIMIT    = 2000;
   localparam int PHASE_ITEMS   = 45;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   lptsc_req_type req_payload = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   lptsc_rsp_type rsp_payload;
   logic          psel = 1'b0;
   logic          penable = 1'b0;
   logic          pwrite = 1'b0;
   logic [1:0]    paddr = '0;
   logic [31:0]   pwdata = '0;
   logic [31:0]   prdata;
   logic          pready;

   length_prefixed_to_start_code_nal_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #5 clock = ~clock;

   lptsc_req_type   pending_items[$];
   lptsc_rsp_type   annexb_due[$];
   int              queued_items = 0;
   int              mismatches = 0;
   int              idle_cycles = 0;
   logic            req_fire = 1'b0;

   // mirror of the converter state
   logic [2:0]      model_len_bytes = LEN_BYTES_RESET;
   lptsc_phase_type model_phase = PH_LEN;
   logic [1:0]      model_prefix = '0;
   logic [31:0]     model_remaining = '0;

   // sender burst and receiver stall pattern
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_span = 0;
   int stall_period = 2;
   int stall_on = 1;
   int stall_cycle = 0;

   logic [2:0] len_settings [8] = '{3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6, 3'd4, 3'd2};

   function automatic int clamp_len_bytes(logic [2:0] v);
      if (v < LEN_BYTES_MIN) return int'(LEN_BYTES_MIN);
      if (v > LEN_BYTES_MAX) return int'(LEN_BYTES_MAX);
      return int'(v);
   endfunction

   function automatic void predict_annexb(lptsc_req_type it);
      lptsc_rsp_type beats[$];
      lptsc_rsp_type beat;
      int            nb;
      int            k;
      logic          with_sc;
      logic          sc_end;
      logic          with_byte;
      logic          fin;
      logic          cut;
      logic [5:0]    utype;
      nb = clamp_len_bytes(model_len_bytes);
      with_sc = 1'b0;
      sc_end = 1'b0;
      with_byte = 1'b0;
      case (model_phase)
         PH_LEN: begin
            model_remaining = {model_remaining[23:0], it.data_byte};
            if (int'(model_prefix) + 1 >= nb) begin
               model_prefix = '0;
               if (model_remaining == 32'd0) begin
                  with_sc = 1'b1;
                  sc_end = 1'b1;
               end else begin
                  model_phase = PH_FIRST;
               end
            end else begin
               model_prefix = model_prefix + 2'd1;
            end
         end
         PH_FIRST: begin
            utype = it.data_byte[6:1];
            model_remaining = model_remaining - 32'd1;
            if (utype == TYPE_VPS || utype == TYPE_SPS || utype == TYPE_PPS) begin
               if (model_remaining == 32'd0) model_phase = PH_LEN;
               else model_phase = PH_DROP;
            end else begin
               with_sc = 1'b1;
               with_byte = 1'b1;
               if (model_remaining == 32'd0) model_phase = PH_LEN;
               else model_phase = PH_COPY;
            end
         end
         PH_COPY: begin
            model_remaining = model_remaining - 32'd1;
            with_byte = 1'b1;
            if (model_remaining == 32'd0) model_phase = PH_LEN;
         end
         default: begin
            model_remaining = model_remaining - 32'd1;
            if (model_remaining == 32'd0) model_phase = PH_LEN;
         end
      endcase
      fin = (model_remaining == 32'd0) || it.end_of_sample;
      cut = it.end_of_sample && (model_remaining != 32'd0);
      beat = '0;
      beat.out_tag = it.frame_tag;
      if (with_sc) begin
         for (k = 0; k < 4; k++) begin
            beat.out_byte = (k == 3) ? START_CODE_LAST : START_CODE_ZERO;
            beat.unit_end = (k == 3) && sc_end;
            beats.push_back(beat);
         end
      end
      if (with_byte) begin
         beat.out_byte = it.data_byte;
         beat.unit_end = fin;
         beat.truncated = cut;
         beats.push_back(beat);
      end
      if (it.end_of_sample) begin
         model_phase = PH_LEN;
         model_prefix = '0;
         model_remaining = '0;
      end
      if (beats.size() > 0) beats[beats.size() - 1].step_last = 1'b1;
      foreach (beats[k]) annexb_due.push_back(beats[k]);
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // sampling, prediction and checking
   always @(posedge clock) begin
      lptsc_rsp_type want;
      logic          rsp_fire;
      logic          csr_write;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      csr_write = !reset && psel && penable && pwrite && pready;
      if (req_fire) predict_annexb(req_payload);
      if (csr_write && paddr == LEN_BYTES_ADDR) model_len_bytes = pwdata[2:0];
      if (rsp_fire) begin
         if (annexb_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_payload));
         end else begin
            want = annexb_due.pop_front();
            if (rsp_payload.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %h, want %h",
                                         rsp_payload.out_byte, want.out_byte));
            if (rsp_payload.unit_end !== want.unit_end)
               report_mismatch($sformatf("unit_end %b, want %b",
                                         rsp_payload.unit_end, want.unit_end));
            if (rsp_payload.truncated !== want.truncated)
               report_mismatch($sformatf("truncated %b, want %b",
                                         rsp_payload.truncated, want.truncated));
            if (rsp_payload.out_tag !== want.out_tag)
               report_mismatch($sformatf("out_tag %h, want %h",
                                         rsp_payload.out_tag, want.out_tag));
            if (rsp_payload.step_last !== want.step_last)
               report_mismatch($sformatf("step_last %b, want %b",
                                         rsp_payload.step_last, want.step_last));
         end
      end
      if (req_fire || rsp_fire || csr_write) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // input transfers in bursts, receiver stall on its own pattern
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 150);
            stall_period = $urandom_range(2, 9);
            stall_on = $urandom_range(1, stall_period - 1);
         end else begin
            stall_span--;
         end
         stall_cycle++;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 6);
            default: rsp_stall <= ((stall_cycle % stall_period) < stall_on);
         endcase
         if (!req_valid || req_fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_payload <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic push_byte(logic [7:0] data, logic eos);
      lptsc_req_type it;
      it.data_byte = data;
      it.end_of_sample = eos;
      it.frame_tag = 2'($urandom_range(0, 3));
      pending_items.push_back(it);
      queued_items++;
   endtask

   // one unit: prefix, then payload that may end early on end of sample
   task automatic queue_unit(int nb);
      logic [31:0] len;
      logic [5:0]  utype;
      logic        cut;
      int          body;
      int          k;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 6) len = '0;
      else if (r < 88) len = $urandom_range(1, 6);
      else len = $urandom();
      if (nb < 4) len = len & ((32'd1 << (8 * nb)) - 32'd1);
      if (len > 32'd8 || $urandom_range(0, 4) == 0) begin
         body = $urandom_range(0, (len > 32'd8) ? 8 : int'(len));
         cut = 1'b1;
      end else begin
         body = int'(len);
         cut = ($urandom_range(0, 5) == 0);
      end
      for (k = nb - 1; k >= 0; k--)
         push_byte(len[8*k +: 8], (k == 0) && (body == 0) && cut);
      r = $urandom_range(0, 99);
      if (r < 30) utype = TYPE_VPS + 6'($urandom_range(0, 2));
      else if (r < 40) utype = ($urandom_range(0, 1) == 0) ? TYPE_VPS - 6'd1 : TYPE_PPS + 6'd1;
      else utype = 6'($urandom_range(0, 63));
      for (k = 0; k < body; k++) begin
         if (k == 0)
            push_byte({1'($urandom_range(0, 1)), utype, 1'($urandom_range(0, 1))},
                      (body == 1) && cut);
         else
            push_byte(8'($urandom_range(0, 255)), (k == body - 1) && cut);
      end
   endtask

   task automatic fill_random(logic [2:0] setting);
      int start_count;
      int n;
      int k;
      start_count = queued_items;
      while (queued_items - start_count < PHASE_ITEMS) begin
         if ($urandom_range(0, 99) < 85) begin
            queue_unit(clamp_len_bytes(setting));
         end else begin
            // noise, always closed by end of sample
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++)
               push_byte(8'($urandom_range(0, 255)),
                         (k == n - 1) || ($urandom_range(0, 4) == 0));
         end
      end
   endtask

   task automatic drain_idle();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || annexb_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_len_bytes(logic [2:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= LEN_BYTES_ADDR;
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      int i;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_len_bytes(LEN_BYTES_RESET);
      // zero-length unit
      push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      // parameter set with maximal length, ended by end of sample
      push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
      push_byte(8'h41, 1'b0); push_byte(8'h99, 1'b1);
      // complete prefix, sample ends before any payload
      push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0); push_byte(8'h05, 1'b1);
      // sample ends inside a prefix
      push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b1);
      // copied unit cut short
      push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0); push_byte(8'h03, 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b1);
      // leave a partial prefix, then shrink the prefix length under it
      push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
      drain_idle();
      write_len_bytes(LEN_BYTES_MIN);
      push_byte(8'h05, 1'b0); push_byte(8'h02, 1'b1);
      fill_random(LEN_BYTES_MIN);
      for (i = 0; i < 8; i++) begin
         drain_idle();
         write_len_bytes(len_settings[i]);
         fill_random(len_settings[i]);
      end
      drain_idle();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### length_prefixed_to_start_code_nal_top.f
rtl/lptsc_pkg.sv
rtl/lptsc_front.sv
rtl/lptsc_queue.sv
rtl/lptsc_back.sv
rtl/length_prefixed_to_start_code_nal_top.sv
bench/length_prefixed_to_start_code_nal_top_tb.sv
